### rtl/assert_macros.svh
// Assertion macros shared by the frame parser RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### rtl/rsfp_pkg.sv
// Types and constants for the range sensor frame parser.
// No dependencies; used by rsfp_core and the top level.
package rsfp_pkg;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int DIST_W     = 20;
  localparam int STRENGTH_W = 16;
  localparam int STORED     = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_RESET       = 8'd89;
  localparam logic [CNT_W-1:0]  TIMEOUT_RESET    = 24'd100000;
  localparam logic [CNT_W-1:0]  STALE_RESET      = 24'd500000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TMO   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_THR   = 4'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADSUM  = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_CRASHED = 2'd3
  } status_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    status_t               status;
    logic [DIST_W-1:0]     distance_scaled;
    logic [STRENGTH_W-1:0] strength;
    logic [BYTE_W-1:0]     credibility;
  } result_t;

endpackage

### rtl/range_sensor_frame_parser_top.sv
// Top level of the range sensor frame parser: ports, output register and
// skid stage. Depends on rsfp_pkg, rsfp_core and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): each transfer is one item, either a
//   received UART byte (in_command = 0, byte on in_rx_byte) or one time tick
//   (in_command = 1). Items are taken one per cycle while in_stall is low.
//   Result channel (out_valid / out_stall): a finished frame, a frame
//   timeout or a staleness crossing gives one result with out_status and,
//   for a good frame, distance times ten, strength and credibility.
//   Each result is registered in the output register, or in the skid stage
//   while the receiver stalls. Throughput: one item per cycle while in_stall
//   is low, set by the single register stage of the parser state.
//   When the receiver stalls, the output register holds its result and a
//   one-entry skid stage catches one more; in_stall rises only while the
//   skid stage is full, so at most one result waits behind the output.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while the block is idle.
//   Reset (rst_n low, synchronous): registers return to their reset values,
//   the parser hunts for a header and both result stages are emptied.
`include "assert_macros.svh"

module range_sensor_frame_parser_top #(
  parameter int PAYLOAD_BYTES = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [rsfp_pkg::BYTE_W-1:0]        in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [rsfp_pkg::DIST_W-1:0]        out_distance_scaled,
  output logic [rsfp_pkg::STRENGTH_W-1:0]    out_strength,
  output logic [rsfp_pkg::BYTE_W-1:0]        out_credibility,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsfp_pkg::CNT_W-1:0]         cfg_data
);
  import rsfp_pkg::*;

  cfg_wr_t cfg_wr;
  logic    acc;
  logic    res_valid;
  result_t res;
  logic    out_take;

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{we: cfg_valid, index: cfg_index, data: cfg_data};
  assign in_stall  = skid_valid_r;
  assign acc       = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  rsfp_core #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .acc      (acc),
    .command  (in_command),
    .rx_byte  (in_rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take)
        out_valid_r <= 1'b1;
      else
        skid_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of both stages; no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take)
        out_r <= skid_r;
    end else if (res_valid) begin
      if (!out_valid_r || out_take)
        out_r <= res;
      else
        skid_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_distance_scaled = out_r.distance_scaled;
  assign out_strength        = out_r.strength;
  assign out_credibility     = out_r.credibility;

  `ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r,
    "skid entry held with empty output register")
  `ASSERT_NEXT(a_stalled_out_kept, out_valid_r && out_stall, out_valid_r,
    "stalled result dropped")
  `ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r,
    "skid entry not moved on transfer")

endmodule

### rtl/rsfp_core.sv
// Frame parser core: configuration registers, header hunt, payload capture,
// checksum and tick counters. Depends on rsfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsfp_core #(
  parameter int PAYLOAD_BYTES = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rsfp_pkg::cfg_wr_t        cfg_wr,
  input  logic                     acc,
  input  logic                     command,
  input  logic [rsfp_pkg::BYTE_W-1:0] rx_byte,
  output logic                     res_valid,
  output rsfp_pkg::result_t        res
);
  import rsfp_pkg::*;

  localparam int POS_W = $clog2(PAYLOAD_BYTES + 2);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_HUNT = '0;

  logic [BYTE_W-1:0] sync_first_r, sync_second_r;
  logic [CNT_W-1:0]  frame_tmo_r, stale_thr_r;

  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]  ft_r, ft_nxt;
  logic [CNT_W-1:0]  stale_r, stale_nxt;
  logic              crash_r, crash_nxt;
  logic [BYTE_W-1:0] payload_r [STORED];

  logic [CNT_W-1:0]      ft_inc, stale_inc;
  logic [STRENGTH_W-1:0] dist_raw;

  // Configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_RESET;
      sync_second_r <= SYNC_RESET;
      frame_tmo_r   <= TIMEOUT_RESET;
      stale_thr_r   <= STALE_RESET;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_wr.data[BYTE_W-1:0];
        REG_SYNC_SECOND: sync_second_r <= cfg_wr.data[BYTE_W-1:0];
        REG_FRAME_TMO:   frame_tmo_r   <= cfg_wr.data;
        REG_STALE_THR:   stale_thr_r   <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      pos_r   <= POS_HUNT;
      sum_r   <= '0;
      ft_r    <= '0;
      stale_r <= '0;
      crash_r <= 1'b0;
    end else begin
      prev_r  <= prev_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      ft_r    <= ft_nxt;
      stale_r <= stale_nxt;
      crash_r <= crash_nxt;
    end
  end

  // Capture the first payload bytes, each at its own frame position
  always_ff @(posedge clk) begin
    for (int i = 0; i < STORED; i++) begin
      if (acc && !command && pos_r == POS_W'(i + 1))
        payload_r[i] <= rx_byte;
    end
  end

  // Saturating tick increments
  assign stale_inc = (stale_r == CNT_MAX) ? stale_r : stale_r + CNT_W'(1);
  assign ft_inc    = (ft_r == CNT_MAX) ? ft_r : ft_r + CNT_W'(1);
  assign dist_raw  = {payload_r[1], payload_r[0]};

  // Next state and result for one accepted item
  always_comb begin
    prev_nxt  = prev_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    ft_nxt    = ft_r;
    stale_nxt = stale_r;
    crash_nxt = crash_r;
    res_valid = 1'b0;
    res       = '{status: ST_OK, distance_scaled: '0, strength: '0, credibility: '0};
    if (acc) begin
      if (command) begin
        // time tick
        stale_nxt = stale_inc;
        if (pos_r != POS_HUNT && ft_inc > frame_tmo_r) begin
          pos_nxt   = POS_HUNT;
          prev_nxt  = '0;
          sum_nxt   = '0;
          ft_nxt    = '0;
          res_valid = 1'b1;
          if (stale_inc > stale_thr_r) begin
            res.status = ST_CRASHED;
            crash_nxt  = 1'b1;
          end else begin
            res.status = ST_TIMEOUT;
          end
        end else begin
          if (pos_r != POS_HUNT)
            ft_nxt = ft_inc;
          if (stale_inc > stale_thr_r && !crash_r) begin
            res_valid  = 1'b1;
            res.status = ST_CRASHED;
            crash_nxt  = 1'b1;
          end
        end
      end else if (pos_r == POS_HUNT) begin
        // hunt for the header pair
        if (prev_r == sync_first_r && rx_byte == sync_second_r) begin
          pos_nxt = POS_W'(1);
          sum_nxt = sync_first_r + sync_second_r;
          ft_nxt  = '0;
        end
        prev_nxt = rx_byte;
      end else if (pos_r <= POS_LAST) begin
        // payload byte
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        // checksum byte closes the frame
        pos_nxt   = POS_HUNT;
        prev_nxt  = '0;
        sum_nxt   = '0;
        ft_nxt    = '0;
        res_valid = 1'b1;
        if (sum_r == rx_byte) begin
          stale_nxt           = '0;
          crash_nxt           = 1'b0;
          res.status          = ST_OK;
          res.distance_scaled = (DIST_W'(dist_raw) << 3) + (DIST_W'(dist_raw) << 1);
          res.strength        = {payload_r[3], payload_r[2]};
          res.credibility     = payload_r[4];
        end else if (stale_r > stale_thr_r) begin
          res.status = ST_CRASHED;
          crash_nxt  = 1'b1;
        end else begin
          res.status = ST_BADSUM;
        end
      end
    end
  end

  `ASSERT_NEXT(a_crash_marks, res_valid && res.status == ST_CRASHED, crash_r,
    "crashed result without crash flag")
  `ASSERT_NEXT(a_ok_clears_stale, res_valid && res.status == ST_OK,
    stale_r == '0 && !crash_r, "good frame did not clear staleness")
  `ASSERT_IMP(a_hunt_no_ticks, pos_r == POS_HUNT, ft_r == '0,
    "frame tick count left over while hunting")

endmodule

### test/tb_top.sv
// Testbench for range_sensor_frame_parser_top: a directed table of frames and ticks,
// then random byte/tick streams, each result checked against the table or an in-bench parser model.
// Depends on rsfp_pkg and the frame parser RTL; reads no files.
`timescale 1ns / 100ps

module tb_top;
  import rsfp_pkg::*;

  localparam int PAYLOAD_LEN  = 6;
  localparam int DIST_SCALE   = 10;
  localparam int WATCHDOG_MAX = 2000;
  localparam int HOLDOFF_LEN  = 300;
  localparam int SETTLE_LEN   = 6;
  localparam int RANDOM_ITEMS = 600;
  localparam int SETTINGS_NUM = 15;
  localparam int SCRIPT_LEN   = 30;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd11;

  typedef enum logic [1:0] {ROW_BYTE, ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CNT_W-1:0]     val;
    logic                 typed;
    result_t              want;
  } step_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t FULL_SCALE = '{ST_OK, 20'd655350, 16'd65535, 8'd255};
  localparam result_t BAD_SUM    = '{ST_BADSUM, 20'd0, 16'd0, 8'd0};
  localparam result_t TIMED_OUT  = '{ST_TIMEOUT, 20'd0, 16'd0, 8'd0};
  localparam result_t CRASHED    = '{ST_CRASHED, 20'd0, 16'd0, 8'd0};

  // Directed table, under reset settings until the two register rows
  localparam step_t SCRIPT [SCRIPT_LEN] = '{
    // largest payload, good checksum
    '{ROW_BYTE, '0, 24'd89,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd89,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd255, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd255, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd255, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd255, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd255, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd0,   1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd173, 1'b1, FULL_SCALE},
    // mixed payload with a tick inside, wrong checksum
    '{ROW_BYTE, '0, 24'd89,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd89,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'h12,  1'b0, NO_RESULT},
    '{ROW_TICK, '0, 24'hA5,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'h34,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'h56,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'h78,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'h9A,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'hBC,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'h00,  1'b1, BAD_SUM},
    // shortest frame timeout, low staleness limit
    '{ROW_CFG, REG_FRAME_TMO, 24'd1, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_STALE_THR, 24'd3, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd89,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd89,  1'b0, NO_RESULT},
    '{ROW_TICK, '0, 24'h00,  1'b0, NO_RESULT},
    '{ROW_TICK, '0, 24'hFF,  1'b1, TIMED_OUT},
    // staleness crossing while hunting
    '{ROW_TICK, '0, 24'h5A,  1'b1, CRASHED},
    '{ROW_BYTE, '0, 24'd89,  1'b0, NO_RESULT},
    '{ROW_BYTE, '0, 24'd89,  1'b0, NO_RESULT},
    '{ROW_TICK, '0, 24'h00,  1'b0, NO_RESULT},
    // timeout while stale
    '{ROW_TICK, '0, 24'h00,  1'b1, CRASHED}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_BYTE;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic [DIST_W-1:0]     out_distance_scaled;
  logic [STRENGTH_W-1:0] out_strength;
  logic [BYTE_W-1:0]     out_credibility;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CNT_W-1:0]      cfg_data = '0;

  // Parser model: settings and state
  logic [BYTE_W-1:0] sync_a, sync_b;
  logic [CNT_W-1:0]  tmo_limit, stale_limit;
  logic [BYTE_W-1:0] last_byte, frame_sum;
  logic [3:0]        frame_pos;
  logic [BYTE_W-1:0] frame_store [STORED];
  logic [CNT_W-1:0]  frame_age, stale_age;
  logic              crash_sent;

  result_t pending_results [$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      holdoff_req = 1'b0;

  range_sensor_frame_parser_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_distance_scaled (out_distance_scaled),
    .out_strength        (out_strength),
    .out_credibility     (out_credibility),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  // Return to hunting with a cleared history
  function automatic void close_frame();
    frame_pos = '0;
    last_byte = '0;
    frame_sum = '0;
    frame_age = '0;
  endfunction

  // Promote an error to crashed once the sensor has gone stale
  function automatic status_t error_code(input status_t code);
    if (stale_age > stale_limit) begin
      crash_sent = 1'b1;
      return ST_CRASHED;
    end
    return code;
  endfunction

  // Advance the parser model by one item; returns 1 when a result is due
  function automatic bit parse_item(input logic cmd, input logic [BYTE_W-1:0] rx,
                                    output result_t res);
    bit sum_ok;
    res = '0;
    if (cmd == CMD_TICK) begin
      if (stale_age != CNT_MAX) stale_age++;
      if (frame_pos != 0) begin
        if (frame_age != CNT_MAX) frame_age++;
        if (frame_age > tmo_limit) begin
          close_frame();
          res.status = error_code(ST_TIMEOUT);
          return 1'b1;
        end
      end
      if (stale_age > stale_limit && !crash_sent) begin
        crash_sent = 1'b1;
        res.status = ST_CRASHED;
        return 1'b1;
      end
      return 1'b0;
    end
    // hunt for the two header bytes
    if (frame_pos == 0) begin
      if (last_byte == sync_a && rx == sync_b) begin
        frame_pos = 4'd1;
        frame_sum = sync_a + sync_b;
        frame_age = '0;
      end
      last_byte = rx;
      return 1'b0;
    end
    // collect payload; the sixth byte only enters the sum
    if (frame_pos <= PAYLOAD_LEN) begin
      if (frame_pos <= STORED) frame_store[frame_pos - 1] = rx;
      frame_sum += rx;
      frame_pos++;
      return 1'b0;
    end
    // checksum byte closes the frame
    sum_ok = (frame_sum == rx);
    close_frame();
    if (!sum_ok) begin
      res.status = error_code(ST_BADSUM);
      return 1'b1;
    end
    stale_age  = '0;
    crash_sent = 1'b0;
    res.status          = ST_OK;
    res.distance_scaled = DIST_W'({frame_store[1], frame_store[0]}) * DIST_W'(DIST_SCALE);
    res.strength        = {frame_store[3], frame_store[2]};
    res.credibility     = frame_store[4];
    return 1'b1;
  endfunction

  // Offer one item, hold it until the transfer, then record what it should give
  task automatic push_item(input logic cmd, input logic [BYTE_W-1:0] rx,
                           input logic typed, input result_t typed_res);
    result_t res;
    bit      gives;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= rx;
    do @(posedge clk); while (in_stall);
    gives = parse_item(cmd, rx, res);
    if (typed) pending_results.push_back(typed_res);
    else if (gives) pending_results.push_back(res);
    items_sent++;
  endtask

  // Drop the input, let every expected result arrive, then cover items still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:  sync_a      = data[BYTE_W-1:0];
      REG_SYNC_SECOND: sync_b      = data[BYTE_W-1:0];
      REG_FRAME_TMO:   tmo_limit   = data;
      REG_STALE_THR:   stale_limit = data;
      default: ;
    endcase
  endtask

  // Close any frame left open, then send a header, payload and checksum
  // with the odd burst of ticks in between
  task automatic send_frame(input bit corrupt);
    logic [BYTE_W-1:0] body [PAYLOAD_LEN+3];
    logic [BYTE_W-1:0] csum;
    int n;
    body[0] = sync_a;
    body[1] = sync_b;
    csum = sync_a + sync_b;
    for (n = 2; n < PAYLOAD_LEN + 2; n++) begin
      body[n] = any_byte();
      csum += body[n];
    end
    body[PAYLOAD_LEN+2] = corrupt ? csum ^ BYTE_W'($urandom_range(1, 255)) : csum;
    while (frame_pos != 0) push_item(CMD_BYTE, any_byte(), 1'b0, NO_RESULT);
    for (n = 0; n < PAYLOAD_LEN + 3; n++) begin
      if ($urandom_range(99) < 12)
        repeat ($urandom_range(1, 3)) push_item(CMD_TICK, any_byte(), 1'b0, NO_RESULT);
      push_item(CMD_BYTE, body[n], 1'b0, NO_RESULT);
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_LEN) @(posedge clk);
        holdoff_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t seen, want;
    if (rst_n && out_valid && !out_stall) begin
      seen.status          = status_t'(out_status);
      seen.distance_scaled = out_distance_scaled;
      seen.strength        = out_strength;
      seen.credibility     = out_credibility;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d distance %0d strength %0d cred %0d",
                   seen.status, seen.distance_scaled, seen.strength, seen.credibility);
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status || seen.distance_scaled !== want.distance_scaled ||
            seen.strength !== want.strength || seen.credibility !== want.credibility) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.status, want.distance_scaled, want.strength, want.credibility,
                     seen.status, seen.distance_scaled, seen.strength, seen.credibility);
        end
      end
    end
  end

  // End the run when no transfer happens on any channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_MAX) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int row, setting, target, pick;
    sync_a      = SYNC_RESET;
    sync_b      = SYNC_RESET;
    tmo_limit   = TIMEOUT_RESET;
    stale_limit = STALE_RESET;
    last_byte   = '0;
    frame_sum   = '0;
    frame_pos   = '0;
    frame_age   = '0;
    stale_age   = '0;
    crash_sent  = 1'b0;
    for (row = 0; row < STORED; row++) frame_store[row] = '0;
    send_idle_pct = 26;
    recv_idle_pct = 61;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (row = 0; row < SCRIPT_LEN; row++) begin
      if (SCRIPT[row].kind == ROW_CFG)
        write_reg(SCRIPT[row].idx, SCRIPT[row].val);
      else
        push_item(SCRIPT[row].kind == ROW_TICK ? CMD_TICK : CMD_BYTE,
                  SCRIPT[row].val[BYTE_W-1:0], SCRIPT[row].typed, SCRIPT[row].want);
    end

    // random part: three idling phases of five register settings each
    for (setting = 0; setting < SETTINGS_NUM; setting++) begin
      case (setting / 5)
        0:       begin send_idle_pct = 26; recv_idle_pct = 61; end
        1:       begin send_idle_pct = 61; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case (setting % 5)
        0: begin
          // zero first header byte, shortest limits
          write_reg(REG_SYNC_FIRST, '0);
          write_reg(REG_SYNC_SECOND, CNT_W'($urandom_range(1, 255)));
          write_reg(REG_FRAME_TMO, CNT_W'(1));
          write_reg(REG_STALE_THR, CNT_W'(1));
        end
        1: begin
          // top values: limits that never fire
          write_reg(REG_SYNC_FIRST, CNT_W'(255));
          write_reg(REG_SYNC_SECOND, CNT_W'(255));
          write_reg(REG_FRAME_TMO, CNT_MAX);
          write_reg(REG_STALE_THR, CNT_MAX);
        end
        2: begin
          write_reg(REG_SYNC_FIRST, CNT_W'(any_byte()));
          write_reg(REG_SYNC_SECOND, CNT_W'(any_byte()));
          write_reg(REG_FRAME_TMO, CNT_W'($urandom_range(1, 12)));
          write_reg(REG_STALE_THR, CNT_W'($urandom_range(4, 40)));
        end
        3: begin
          // equal header bytes
          write_reg(REG_SYNC_FIRST, CNT_W'(any_byte()));
          write_reg(REG_SYNC_SECOND, CNT_W'(sync_a));
          write_reg(REG_FRAME_TMO, CNT_W'($urandom_range(2, 12)));
          write_reg(REG_STALE_THR, CNT_MAX);
        end
        default: begin
          write_reg(REG_SYNC_FIRST, CNT_W'(any_byte()));
          write_reg(REG_SYNC_SECOND, CNT_W'(any_byte()));
          write_reg(REG_FRAME_TMO, CNT_MAX);
          write_reg(REG_STALE_THR, CNT_W'($urandom_range(1, 30)));
        end
      endcase
      if (setting == 0) write_reg(REG_SPARE, CNT_W'($urandom));
      // long receiver hold-off while frames keep coming
      if (setting == 1 || setting == 11) holdoff_req = 1'b1;

      target = items_sent + RANDOM_ITEMS / SETTINGS_NUM;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 55)
          send_frame(1'b0);
        else if (pick < 70)
          send_frame(1'b1);
        else if (pick < 82) begin
          // open a frame, then let it age out
          while (frame_pos != 0) push_item(CMD_BYTE, any_byte(), 1'b0, NO_RESULT);
          push_item(CMD_BYTE, sync_a, 1'b0, NO_RESULT);
          push_item(CMD_BYTE, sync_b, 1'b0, NO_RESULT);
          repeat ($urandom_range(0, PAYLOAD_LEN))
            push_item(CMD_BYTE, any_byte(), 1'b0, NO_RESULT);
          repeat ($urandom_range(1, 40)) push_item(CMD_TICK, any_byte(), 1'b0, NO_RESULT);
        end else
          repeat ($urandom_range(1, 6))
            push_item(1'($urandom_range(1)), any_byte(), 1'b0, NO_RESULT);
      end
    end

    settle();
    if (fail_count == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
